FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the filter RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WMF_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("window median filter assertion failed");
`define WMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window median filter assertion failed");
`else
`define WMF_ASSERT(lbl, cond)
`define WMF_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/wmf_pkg.sv
// Constants, types and helper functions of the window median filter.
package wmf_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 3;
  localparam int WIN        = 2 * MAX_RADIUS + 1;
  localparam int CELLS      = WIN * WIN;
  localparam int LINES      = 2 * MAX_RADIUS;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int RAD_W      = 2;
  localparam int LAG_W      = 12;
  localparam int RANK_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_BITS  = LINES * PIX_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  // Kinds of input word.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // One stage of the bitwise rank selection.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [RANK_W-1:0]       rank;
    logic [CELLS-1:0]        cand;
    logic [CELLS-1:0][PIX_W-1:0] vals;
    pix_t                    res;
  } sel_stage_t;

  // Rank of the median among (2r+1)^2 window values.
  function automatic logic [RANK_W-1:0] median_rank(input logic [RAD_W-1:0] r);
    logic [RANK_W-1:0] k;
    unique case (r)
      2'd0: k = 6'd0;
      2'd1: k = 6'd4;
      2'd2: k = 6'd12;
      2'd3: k = 6'd24;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [RANK_W-1:0] count_cells(input logic [CELLS-1:0] v);
    logic [RANK_W-1:0] n;
    n = '0;
    for (int i = 0; i < CELLS; i++) n = n + RANK_W'(v[i]);
    return n;
  endfunction

endpackage

FILE: rtl/core/window_median_filter_core.sv
// Streaming zero-padded 2-D median filter with line memory and rank-select pipeline.
//
// Usage: grayscale pixels enter in raster order on the in_ channel, one word per
// clock while in_tready is high. in_tuser is 0 for a pixel and 1 for a drain
// word; after the last pixel of a frame the source sends drain words that stand
// for the bottom and right padding. The result for a pixel appears once
// radius*width+radius words have been taken after it; out_tlast marks the final
// result of the frame. Drain words after the frame is complete produce nothing;
// the next pixel word opens a new frame. Writing any register through the cfg_
// port restarts the frame. Throughput: one word per cycle while no stall holds
// the pipeline; the line memory is read on acceptance and written back from
// stage 1, where a write to the same column is forwarded to the read.
// The history of the last six rows lives in one 1024 x 48 memory, each word
// holding one column of all six rows; the median is found by an 8-stage
// bitwise rank selection over the 49 window cells.
// Reset: registers return to width 640, height 480, radius 1, counters clear;
// the line memory is not cleared, rows above the image are masked instead.
// Stall: while a result waits on a low out_tready, the pipeline keeps moving
// as long as its last stage holds no result, so bubbles are squeezed out.
`include "assert_macros.svh"

module window_median_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] pixel_value
  input  logic                              in_tuser,   // [0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] median_value
  output logic                              out_tlast,  // frame_last
  input  logic                              cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PW = wmf_pkg::PIX_W;

  // Configuration, stored already clamped to the supported range.
  logic [wmf_pkg::WID_W-1:0] w_r;
  logic [wmf_pkg::HGT_W-1:0] h_r;
  logic [wmf_pkg::RAD_W-1:0] r_r;
  logic [wmf_pkg::LAG_W-1:0] lag;

  // Frame position state.
  logic [wmf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [wmf_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      full_r, full_nxt;
  logic [wmf_pkg::LAG_W-1:0] d_r, d_nxt;
  logic [wmf_pkg::COL_W-1:0] x_r, x_nxt;
  logic [wmf_pkg::ROW_W-1:0] y_r, y_nxt;
  logic                      done_r, done_nxt;

  logic ce, accept, restart, drop, emit, pos_last;
  logic [wmf_pkg::COL_W-1:0] b_col, b_x;
  logic [wmf_pkg::ROW_W-1:0] b_row, b_y;
  logic                      b_full;
  logic [wmf_pkg::LAG_W-1:0] b_d, d_inc;
  wmf_pkg::pix_t             wval;
  logic                      col_last, x_last;

  // Stage 1: memory read data available.
  logic                      s1_valid_r, s1_emit_r, s1_last_r, s1_fwd_r;
  logic [wmf_pkg::COL_W-1:0] s1_col_r, s1_x_r;
  logic [wmf_pkg::ROW_W-1:0] s1_y_r;
  wmf_pkg::pix_t             s1_pix_r;
  logic [wmf_pkg::LINE_BITS-1:0] rd_r, wlast_r, old_word, new_word;
  logic [wmf_pkg::LINE_BITS-1:0] lb_mem [wmf_pkg::MAX_WIDTH];

  wmf_pkg::pix_t column [wmf_pkg::WIN];
  wmf_pkg::pix_t win_r  [wmf_pkg::WIN][wmf_pkg::WIN];

  // Stage 2: window complete for the item.
  logic                      s2_valid_r, s2_last_r;
  logic [wmf_pkg::COL_W-1:0] s2_x_r;
  logic [wmf_pkg::ROW_W-1:0] s2_y_r;

  logic [wmf_pkg::WIN-1:0]   row_ok, col_ok;
  wmf_pkg::sel_stage_t       sel_first;
  wmf_pkg::sel_stage_t       sel_r [PW+1];
  logic                      out_valid_r, out_last_r;
  wmf_pkg::pix_t             out_data_r;

  assign lag = wmf_pkg::LAG_W'(w_r) * wmf_pkg::LAG_W'(r_r) + wmf_pkg::LAG_W'(r_r)
             + wmf_pkg::LAG_W'(1);

  // The pipeline only stops when a result would overrun a waiting output word.
  assign ce        = !(out_valid_r && !out_tready && sel_r[PW].valid);
  assign in_tready = ce;
  assign accept    = in_tvalid && ce;

  always_comb begin
    restart = done_r && (in_tuser == wmf_pkg::FUNC_PIXEL);
    drop    = done_r && (in_tuser == wmf_pkg::FUNC_DRAIN);
    b_col   = restart ? '0 : col_r;
    b_row   = restart ? '0 : row_r;
    b_full  = restart ? 1'b0 : full_r;
    b_d     = restart ? '0 : d_r;
    b_x     = restart ? '0 : x_r;
    b_y     = restart ? '0 : y_r;
    // Once every pixel of the frame is in, further words count as padding.
    wval     = (!b_full && in_tuser == wmf_pkg::FUNC_PIXEL) ? in_tdata[PW-1:0] : '0;
    col_last = ({1'b0, b_col} == w_r - wmf_pkg::WID_W'(1));
    col_nxt  = col_last ? '0 : b_col + wmf_pkg::COL_W'(1);
    row_nxt  = (!b_full && col_last) ? b_row + wmf_pkg::ROW_W'(1) : b_row;
    full_nxt = b_full || (col_last && ({1'b0, b_row} == h_r - wmf_pkg::HGT_W'(1)));
    d_inc    = b_d + wmf_pkg::LAG_W'(1);
    emit     = (d_inc >= lag);
    d_nxt    = emit ? b_d : d_inc;
    x_last   = ({1'b0, b_x} == w_r - wmf_pkg::WID_W'(1));
    pos_last = x_last && ({1'b0, b_y} == h_r - wmf_pkg::HGT_W'(1));
    x_nxt    = (emit && !x_last) ? b_x + wmf_pkg::COL_W'(1) : (emit ? '0 : b_x);
    y_nxt    = (emit && x_last) ? b_y + wmf_pkg::ROW_W'(1) : b_y;
    done_nxt = (emit && pos_last) || (done_r && !restart);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= wmf_pkg::WID_W'(640);
      h_r    <= wmf_pkg::HGT_W'(480);
      r_r    <= wmf_pkg::RAD_W'(1);
      col_r  <= '0;
      row_r  <= '0;
      full_r <= 1'b0;
      d_r    <= '0;
      x_r    <= '0;
      y_r    <= '0;
      done_r <= 1'b0;
    end else if (cfg_we && (cfg_index == wmf_pkg::REG_WIDTH ||
                            cfg_index == wmf_pkg::REG_HEIGHT ||
                            cfg_index == wmf_pkg::REG_RADIUS)) begin
      unique case (cfg_index)
        wmf_pkg::REG_WIDTH: begin
          if (cfg_wdata[wmf_pkg::WID_W-1:0] == '0) w_r <= wmf_pkg::WID_W'(1);
          else if (cfg_wdata[wmf_pkg::WID_W-1:0] > wmf_pkg::WID_W'(wmf_pkg::MAX_WIDTH))
            w_r <= wmf_pkg::WID_W'(wmf_pkg::MAX_WIDTH);
          else w_r <= cfg_wdata[wmf_pkg::WID_W-1:0];
        end
        wmf_pkg::REG_HEIGHT: begin
          if (cfg_wdata == '0) h_r <= wmf_pkg::HGT_W'(1);
          else if (cfg_wdata > wmf_pkg::HGT_W'(wmf_pkg::MAX_HEIGHT))
            h_r <= wmf_pkg::HGT_W'(wmf_pkg::MAX_HEIGHT);
          else h_r <= cfg_wdata;
        end
        default: r_r <= cfg_wdata[wmf_pkg::RAD_W-1:0];
      endcase
      col_r  <= '0;
      row_r  <= '0;
      full_r <= 1'b0;
      d_r    <= '0;
      x_r    <= '0;
      y_r    <= '0;
      done_r <= 1'b0;
    end else if (accept && !drop) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      full_r <= full_nxt;
      d_r    <= d_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      done_r <= done_nxt;
    end
  end

  // Line memory: read on acceptance, written back with the shifted column.
  always_ff @(posedge clk) begin
    if (ce) rd_r <= lb_mem[b_col];
  end

  always_ff @(posedge clk) begin
    if (ce && s1_valid_r) lb_mem[s1_col_r] <= new_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ce) begin
      s1_valid_r <= accept && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_emit_r <= emit;
      s1_last_r <= pos_last;
      s1_col_r  <= b_col;
      s1_x_r    <= b_x;
      s1_y_r    <= b_y;
      s1_pix_r  <= wval;
      // Same column written back this cycle: the read returns stale data.
      s1_fwd_r  <= s1_valid_r && (s1_col_r == b_col);
      if (s1_valid_r) wlast_r <= new_word;
    end
  end

  always_comb begin
    old_word  = s1_fwd_r ? wlast_r : rd_r;
    new_word  = {old_word[wmf_pkg::LINE_BITS-PW-1:0], s1_pix_r};
    column[0] = s1_pix_r;
    for (int k = 1; k < wmf_pkg::WIN; k++) column[k] = old_word[(k-1)*PW +: PW];
  end

  // Window: row k is k lines above the newest word, column m is m words back.
  always_ff @(posedge clk) begin
    if (ce && s1_valid_r) begin
      for (int k = 0; k < wmf_pkg::WIN; k++) begin
        win_r[k][0] <= column[k];
        for (int m = 1; m < wmf_pkg::WIN; m++) win_r[k][m] <= win_r[k][m-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (ce) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_last_r <= s1_last_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
    end
  end

  // Border masking and restriction to the configured window size.
  always_comb begin
    logic signed [wmf_pkg::ROW_W+2:0] yy;
    logic signed [wmf_pkg::COL_W+2:0] xx;
    for (int k = 0; k < wmf_pkg::WIN; k++) begin
      yy = $signed({3'b000, s2_y_r}) + $signed({{(wmf_pkg::ROW_W+1){1'b0}}, r_r})
         - $signed((wmf_pkg::ROW_W+3)'(k));
      xx = $signed({3'b000, s2_x_r}) + $signed({{(wmf_pkg::COL_W+1){1'b0}}, r_r})
         - $signed((wmf_pkg::COL_W+3)'(k));
      row_ok[k] = (yy >= 0) && (yy < $signed({2'b00, h_r}));
      col_ok[k] = (xx >= 0) && (xx < $signed({2'b00, w_r}));
    end
    sel_first.valid = s2_valid_r;
    sel_first.last  = s2_last_r;
    sel_first.rank  = wmf_pkg::median_rank(r_r);
    sel_first.res   = '0;
    for (int k = 0; k < wmf_pkg::WIN; k++) begin
      for (int m = 0; m < wmf_pkg::WIN; m++) begin
        sel_first.cand[k*wmf_pkg::WIN+m] = (k <= 2 * int'(r_r)) && (m <= 2 * int'(r_r));
        sel_first.vals[k*wmf_pkg::WIN+m] = (row_ok[k] && col_ok[m]) ? win_r[k][m] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r[0].valid <= 1'b0;
    else if (ce) sel_r[0].valid <= sel_first.valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sel_r[0].last <= sel_first.last;
      sel_r[0].rank <= sel_first.rank;
      sel_r[0].cand <= sel_first.cand;
      sel_r[0].vals <= sel_first.vals;
      sel_r[0].res  <= sel_first.res;
    end
  end

  // One result bit per stage, most significant first.
  for (genvar i = 0; i < PW; i++) begin : g_sel
    localparam int BIT = PW - 1 - i;
    logic [wmf_pkg::CELLS-1:0] zeros;
    logic [wmf_pkg::RANK_W-1:0] cnt;
    wmf_pkg::sel_stage_t nxt;

    always_comb begin
      for (int c = 0; c < wmf_pkg::CELLS; c++)
        zeros[c] = sel_r[i].cand[c] && !sel_r[i].vals[c][BIT];
      cnt = wmf_pkg::count_cells(zeros);
      nxt = sel_r[i];
      if (sel_r[i].rank < cnt) begin
        nxt.cand     = zeros;
        nxt.res[BIT] = 1'b0;
      end else begin
        nxt.cand     = sel_r[i].cand & ~zeros;
        nxt.rank     = sel_r[i].rank - cnt;
        nxt.res[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sel_r[i+1].valid <= 1'b0;
      else if (ce) sel_r[i+1].valid <= nxt.valid;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sel_r[i+1].last <= nxt.last;
        sel_r[i+1].rank <= nxt.rank;
        sel_r[i+1].cand <= nxt.cand;
        sel_r[i+1].vals <= nxt.vals;
        sel_r[i+1].res  <= nxt.res;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= sel_r[PW].valid || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (ce && sel_r[PW].valid) begin
      out_data_r <= sel_r[PW].res;
      out_last_r <= sel_r[PW].last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `WMF_ASSERT(a_lag_bound, d_r < lag)
  `WMF_ASSERT_IMPL(a_done_full, done_r, full_r)
  `WMF_ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_tready)
  `WMF_ASSERT_IMPL(a_stall_cause, !in_tready, out_valid_r && !out_tready && sel_r[PW].valid)

endmodule

FILE: test/window_median_filter_core_tb.sv
// Self-checking testbench of the streaming zero-padded window median filter.
module window_median_filter_core_tb;
  import wmf_pkg::*;

  // Depth of the pixel history ring: six rows of the widest frame plus seven words of slack.
  localparam int RING_DEPTH = LINES * MAX_WIDTH + LINES + 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT = 40;
  localparam int RANDOM_WORDS = 850;

  typedef struct {
    logic [7:0] median;
    logic       last;
  } median_result_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // One row of the directed table. For a register row, code is the register
  // index; for a word row, it is the func bit.
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  code;
    logic [12:0] value;
    logic        typed;
    logic [7:0]  t_median;
    logic        t_last;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] pixel_value
  logic                  in_tuser;   // [0] func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [7:0] median_value
  logic                  out_tlast;  // frame_last
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  window_median_filter_core uut (.*);

  // Shadow copy of the filter: registers, pixel history and frame counters.
  logic [10:0] shadow_width;
  logic [12:0] shadow_height;
  logic [1:0]  shadow_radius;
  logic [7:0]  pixel_ring [RING_DEPTH];
  int          words_taken;
  int          medians_given;

  median_result_t pending_medians[$];
  int  fail_count;
  int  cycle_count;
  int  stall_left;
  bit  quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("window_median_filter_core verification failed");
      $finish;
    end
  end

  function automatic int clamped_width();
    if (shadow_width == 0) return 1;
    return (shadow_width > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_width);
  endfunction

  function automatic int clamped_height();
    if (shadow_height == 0) return 1;
    return (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_height);
  endfunction

  // Median of the zero-padded window around linear position pos. Cells
  // outside the image contribute zeros; the window count is always odd.
  function automatic logic [7:0] window_median(int pos);
    int w, h, r, y, x, n, j;
    logic [7:0] cells [CELLS];
    logic [7:0] v;
    w = clamped_width();
    h = clamped_height();
    r = shadow_radius;
    y = pos / w;
    x = pos % w;
    n = 0;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        v = 8'd0;
        if (y + dy >= 0 && y + dy < h && x + dx >= 0 && x + dx < w)
          v = pixel_ring[((y + dy) * w + x + dx) % RING_DEPTH];
        cells[n] = v;
        n++;
      end
    end
    for (int i = 1; i < n; i++) begin
      v = cells[i];
      j = i;
      while (j > 0 && cells[j-1] > v) begin
        cells[j] = cells[j-1];
        j--;
      end
      cells[j] = v;
    end
    return cells[n / 2];
  endfunction

  // Advances the shadow copy by one accepted word and queues the median it
  // releases, if any.
  task automatic absorb_word(input logic func, input logic [7:0] pix);
    int w, h, r, total;
    median_result_t res;
    w = clamped_width();
    h = clamped_height();
    r = shadow_radius;
    total = w * h;
    if (medians_given >= total) begin
      // A finished frame ignores drain words; a pixel opens the next frame.
      if (func == FUNC_DRAIN) return;
      words_taken = 0;
      medians_given = 0;
    end
    if (words_taken < total)
      pixel_ring[words_taken % RING_DEPTH] = (func == FUNC_DRAIN) ? 8'd0 : pix;
    words_taken++;
    if (words_taken < medians_given + r * w + r + 1) return;
    res.median = window_median(medians_given);
    res.last = (medians_given == total - 1);
    pending_medians.push_back(res);
    medians_given++;
  endtask

  // Offers one word on the input channel, now and then with a random idle burst
  // ahead of it, and returns at the falling edge after it has been taken.
  task automatic send_word(input logic func, input logic [7:0] pix);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = func;
    in_tdata = pix;
    do @(posedge clk); while (!in_tready);
    absorb_word(func, pix);
    @(negedge clk);
  endtask

  // Registers change only with the filter idle: every queued median out, then
  // a pause for the pipeline, which may still hold a word with no result.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] value);
    in_tvalid = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  shadow_width = value[10:0];
      REG_HEIGHT: shadow_height = value;
      REG_RADIUS: shadow_radius = value[1:0];
      default: ;
    endcase
    words_taken = 0;
    medians_given = 0;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one frame: its pixels with the odd drain word mixed in, then drain
  // words, now and then a stray pixel, until the last median is out. A cut
  // frame stops early; a later call carries it on until a register write restarts it.
  task automatic send_frame(input bit cut, inout int counted);
    int total, cut_at;
    logic func;
    total = clamped_width() * clamped_height();
    cut_at = $urandom_range(0, total - 1);
    for (int i = 0; i < total; i++) begin
      if (cut && i == cut_at) return;
      func = ($urandom_range(0, 15) == 0) ? FUNC_DRAIN : FUNC_PIXEL;
      send_word(func, random_pixel());
      counted++;
    end
    while (medians_given < total) begin
      func = ($urandom_range(0, 7) == 0) ? FUNC_PIXEL : FUNC_DRAIN;
      send_word(func, random_pixel());
      counted++;
    end
    // Drain words past the end of the frame produce nothing.
    repeat ($urandom_range(0, 2)) send_word(FUNC_DRAIN, random_pixel());
  endtask

  // Result side: random stall bursts, none near the end.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every median taken at a rising edge is matched against the oldest one
  // queued by the shadow copy.
  always @(posedge clk) begin
    median_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected word: median_value %0d frame_last %0d", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_medians.pop_front();
        if (out_tdata !== want.median) begin
          $error("median_value expected %0d actual %0d", want.median, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_last expected %0d actual %0d", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Directed table: a 1x1 frame at radius 0 echoes each pixel and ignores a
  // trailing drain word; at radius 1 it is outvoted by its eight zero
  // neighbors; a 3x2 frame then carries a drain word inside the frame and a
  // pixel word where padding is due.
  stim_row_t directed [] = '{
    '{ROW_CFG,  REG_WIDTH,  13'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  REG_HEIGHT, 13'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  REG_RADIUS, 13'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd255, 1'b1, 8'd255, 1'b1},
    '{ROW_WORD, FUNC_DRAIN, 13'd17,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd0,   1'b1, 8'd0,   1'b1},
    '{ROW_WORD, FUNC_PIXEL, 13'd128, 1'b1, 8'd128, 1'b1},
    '{ROW_CFG,  REG_RADIUS, 13'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd200, 1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd255, 1'b1, 8'd0,   1'b1},
    '{ROW_CFG,  REG_WIDTH,  13'd3,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  REG_HEIGHT, 13'd2,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd10,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd255, 1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd90,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd40,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd50,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd60,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_PIXEL, 13'd99,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, FUNC_DRAIN, 13'd0,   1'b0, 8'd0,   1'b0}
  };

  initial begin
    int counted, queued, wide_runs, tall_runs;
    bit ok;
    in_tvalid = 1'b0;
    in_tuser = FUNC_PIXEL;
    in_tdata = 8'd0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    rst_n = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    stall_left = 0;
    quiet = 1'b0;
    shadow_width = 11'd640;
    shadow_height = 13'd480;
    shadow_radius = 2'd1;
    words_taken = 0;
    medians_given = 0;
    counted = 0;
    wide_runs = 0;
    tall_runs = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].code, directed[i].value);
      end else begin
        queued = pending_medians.size();
        send_word(directed[i].code[0], directed[i].value[7:0]);
        // Hand-written results also cross-check the shadow copy.
        if (directed[i].typed) begin
          ok = pending_medians.size() == queued + 1;
          if (ok) ok = pending_medians[$].median == directed[i].t_median &&
                       pending_medians[$].last == directed[i].t_last;
          if (!ok) begin
            $error("directed row %0d: median_value expected %0d frame_last expected %0d",
                   i, directed[i].t_median, directed[i].t_last);
            fail_count++;
          end
        end
      end
    end

    // Random phases: each sets all three registers, then sends a few frames.
    // Up to two phases each run the widest row and the tallest column; the second
    // of each uses out-of-range register values that clamp to them.
    while (counted < RANDOM_WORDS) begin
      quiet = counted > RANDOM_WORDS * 4 / 5;
      if (wide_runs < 2 && $urandom_range(0, 24) == 0) begin
        write_reg(REG_WIDTH, wide_runs == 0 ? 13'd1024 : 13'd2047);
        write_reg(REG_HEIGHT, wide_runs == 0 ? 13'd1 : 13'd0);
        wide_runs++;
      end else if (tall_runs < 2 && $urandom_range(0, 24) == 0) begin
        write_reg(REG_WIDTH, tall_runs == 0 ? 13'd1 : 13'd0);
        write_reg(REG_HEIGHT, tall_runs == 0 ? 13'd4096 : 13'd8191);
        tall_runs++;
      end else begin
        write_reg(REG_WIDTH, 13'($urandom_range(0, 12)));
        write_reg(REG_HEIGHT, 13'($urandom_range(0, 6)));
      end
      write_reg(REG_RADIUS, 13'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 9) == 0, counted);
    end

    in_tvalid = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("window_median_filter_core verification clean");
    end else begin
      $display("window_median_filter_core verification failed");
    end
    $finish;
  end

endmodule
